@@ src/rdr_pkg.sv @@
package rdr_pkg;

	localparam int CC_W  = 15;
	localparam int ZDR_W = 16;
	localparam int DR_W  = 15;
	localparam int ST_W  = 2;

	// quotient bits of the ratio, 2^30 included
	localparam int Q_W = 31;
	localparam int DIV_STEPS_DEF = 4;

	localparam logic [13:0] CC_MAX             = 14'd16382;
	localparam logic [17:0] LOG2_10_PER_20_Q28 = 18'd174162;
	localparam logic [17:0] DB_PER_LOG2_Q8     = 18'd197283;
	localparam logic [16:0] DR_MIN_MAG         = 17'd16384;

	typedef logic [ST_W-1:0] status_t;

	localparam status_t ST_GOOD    = 2'd0;
	localparam status_t ST_MISSING = 2'd1;
	localparam status_t ST_FOLDED  = 2'd2;

	typedef struct packed {
		logic    vld;
		status_t st;
	} tag_t;

	// integer square root, used only for constants
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] rem;
		logic [63:0] bt;
		res = '0;
		rem = v;
		for (int i = 31; i >= 0; i--) begin
			bt = 64'd1 << (2 * i);
			if (rem >= res + bt) begin
				rem = rem - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q30
	function automatic logic [29:0] root_q30(input int k);
		logic [63:0] r;
		r = 64'd1 << 29;
		for (int i = 1; i <= k; i++) begin
			r = isqrt64(r << 30);
		end
		return r[29:0];
	endfunction

endpackage

@@ src/radar_depolarization_ratio.sv @@
// From input accept to result on the output port, each word passes the 16-stage
// exp2 chain, the pipelined divider and the 16-stage log2 squaring chain.
// Throughput: one word per cycle; a 2-word output buffer keeps input accepted
// while a result waits, so ready only drops once both buffer slots are full.
// Reset: arst_n clears all valid bits and empties the output buffer at once.
module radar_depolarization_ratio #(
	parameter int DIV_STEPS = rdr_pkg::DIV_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // cc_value[14:0], zdr_value[30:15], zero pad
	input  logic [3:0]  s_axis_tuser,  // cc_status[1:0], zdr_status[3:2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // dr_value[14:0], zero pad
	output logic [1:0]  m_axis_tuser   // dr_status[1:0]
);
	import rdr_pkg::*;

	localparam int NEXP = 16;

	logic       en;
	logic [1:0] cnt_q;

	assign en            = (cnt_q != 2'd2);
	assign s_axis_tready = en;

	// input decode
	logic [CC_W-1:0]         cc_value;
	logic signed [ZDR_W-1:0] zdr_value;
	status_t                 cc_status, zdr_status, st_in;

	assign cc_value   = s_axis_tdata[14:0];
	assign zdr_value  = $signed(s_axis_tdata[30:15]);
	assign cc_status  = s_axis_tuser[1:0];
	assign zdr_status = s_axis_tuser[3:2];

	always_comb begin
		if (cc_status == ST_FOLDED || zdr_status == ST_FOLDED) begin
			st_in = ST_FOLDED;
		end else if (cc_status != ST_GOOD || zdr_status != ST_GOOD) begin
			st_in = ST_MISSING;
		end else begin
			st_in = ST_GOOD;
		end
	end

	// stage 1: |zdr|, clamped cc
	tag_t        tag_s1;
	logic [15:0] a_s1;
	logic [13:0] c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (en) begin
			tag_s1 <= '{vld: s_axis_tvalid, st: st_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= zdr_value[15] ? 16'(-zdr_value) : 16'(zdr_value);
			c_s1 <= (cc_value > {1'b0, CC_MAX}) ? CC_MAX : cc_value[13:0];
		end
	end

	// stage 2: log2(1/t) in Q28, split into integer and fraction
	logic [33:0] e_mul;
	tag_t        tag_s2;
	logic [5:0]  n_s2;
	logic [15:0] f_s2;
	logic [13:0] c_s2;

	assign e_mul = 34'(a_s1) * 34'(LOG2_10_PER_20_Q28);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else if (en) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2 <= e_mul[33:28];
			f_s2 <= e_mul[27:12];
			c_s2 <= c_s1;
		end
	end

	// 2^-f, one root constant per stage
	tag_t        exp_tag [0:NEXP];
	logic [30:0] exp_p   [0:NEXP];
	logic [5:0]  exp_n   [0:NEXP];
	logic [15:0] exp_f   [0:NEXP];
	logic [13:0] exp_c   [0:NEXP];

	assign exp_tag[0] = tag_s2;
	assign exp_p[0]   = 31'd1 << 30;
	assign exp_n[0]   = n_s2;
	assign exp_f[0]   = f_s2;
	assign exp_c[0]   = c_s2;

	for (genvar k = 1; k <= NEXP; k++) begin : g_exp
		localparam logic [29:0] RK = root_q30(k);
		logic [61:0] pr;

		assign pr = 62'(exp_p[k-1]) * 62'(RK) + (62'd1 << 29);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				exp_tag[k] <= '0;
			end else if (en) begin
				exp_tag[k] <= exp_tag[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				exp_p[k] <= exp_f[k-1][NEXP-k] ? pr[60:30] : exp_p[k-1];
				exp_n[k] <= exp_n[k-1];
				exp_f[k] <= exp_f[k-1];
				exp_c[k] <= exp_c[k-1];
			end
		end
	end

	// t = 2^-f >> n
	tag_t        tag_s19;
	logic [30:0] t_s19;
	logic [13:0] c_s19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s19 <= '0;
		end else if (en) begin
			tag_s19 <= exp_tag[NEXP];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s19 <= (exp_n[NEXP] >= 6'd31) ? '0 : exp_p[NEXP] >> exp_n[NEXP];
			c_s19 <= exp_c[NEXP];
		end
	end

	// t^2 and 2ct
	logic [61:0] t2_mul;
	logic [45:0] ct_mul;
	tag_t        tag_s20;
	logic [30:0] t2_s20;
	logic [31:0] ct_s20;

	assign t2_mul = 62'(t_s19) * 62'(t_s19) + (62'd1 << 29);
	assign ct_mul = ((46'(c_s19) * 46'(t_s19)) << 1) + (46'd1 << 13);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s20 <= '0;
		end else if (en) begin
			tag_s20 <= tag_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s20 <= t2_mul[60:30];
			ct_s20 <= ct_mul[45:14];
		end
	end

	// numerator and denominator
	logic signed [34:0] num_w;
	tag_t               tag_s21;
	logic [31:0]        num_s21;
	logic [32:0]        den_s21;

	assign num_w = (35'sd1 <<< 30) + $signed({4'b0, t2_s20}) - $signed({3'b0, ct_s20});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s21 <= '0;
		end else if (en) begin
			tag_s21 <= tag_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s21 <= (num_w < 35'sd1) ? 32'd1 : num_w[31:0];
			den_s21 <= (33'd1 << 30) + 33'(t2_s20) + 33'(ct_s20);
		end
	end

	tag_t           div_tag;
	logic [Q_W-1:0] div_q;

	rdr_div #(
		.DIV_STEPS(DIV_STEPS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (tag_s21),
		.num_in (num_s21),
		.den_in (den_s21),
		.tag_out(div_tag),
		.q_out  (div_q)
	);

	tag_t              log_tag;
	logic signed [21:0] log_l;

	rdr_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.tag_in (div_tag),
		.q_in   (div_q),
		.tag_out(log_tag),
		.l_out  (log_l)
	);

	// scale to dB
	tag_t               tag_sp;
	logic signed [40:0] prod_sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_sp <= '0;
		end else if (en) begin
			tag_sp <= log_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_sp <= 41'(log_l) * $signed(41'(DB_PER_LOG2_Q8));
		end
	end

	// round half away from zero, saturate, force positive results to zero, apply status
	logic [40:0]       mag;
	logic [40:0]       rnd;
	logic [16:0]       r17;
	logic [DR_W-1:0]   dr_fin;

	always_comb begin
		mag = prod_sp[40] ? 41'(-prod_sp) : 41'(prod_sp);
		rnd = (mag + (41'd1 << 23)) >> 24;
		r17 = rnd[16:0];
		if (tag_sp.st != ST_GOOD || !prod_sp[40]) begin
			dr_fin = '0;
		end else if (rnd > 41'(DR_MIN_MAG)) begin
			dr_fin = DR_W'(-DR_MIN_MAG);
		end else begin
			dr_fin = DR_W'(-r17);
		end
	end

	// two-word output buffer
	logic [DR_W-1:0] slot_dr_q [0:1];
	status_t         slot_st_q [0:1];
	logic            push, pop;

	assign push = en && tag_sp.vld;
	assign pop  = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					slot_dr_q[0] <= dr_fin;
					slot_st_q[0] <= tag_sp.st;
				end else begin
					slot_dr_q[1] <= dr_fin;
					slot_st_q[1] <= tag_sp.st;
				end
			end
			2'b01: begin
				slot_dr_q[0] <= slot_dr_q[1];
				slot_st_q[0] <= slot_st_q[1];
			end
			2'b11: begin
				slot_dr_q[0] <= dr_fin;
				slot_st_q[0] <= tag_sp.st;
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = (cnt_q != 2'd0);
	assign m_axis_tdata  = {1'b0, slot_dr_q[0]};
	assign m_axis_tuser  = slot_st_q[0];

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push)
		else $error("push into full output buffer");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_GOOD |-> m_axis_tdata == 16'd0)
		else $error("nonzero value on bad status");

	a_dr_nonpos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14] || m_axis_tdata[14:0] == 15'd0)
		else $error("positive depolarization ratio");

endmodule

@@ src/rdr_div.sv @@
module rdr_div #(
	parameter int DIV_STEPS = rdr_pkg::DIV_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rdr_pkg::tag_t tag_in,
	input  logic [31:0]   num_in,
	input  logic [32:0]   den_in,
	output rdr_pkg::tag_t tag_out,
	output logic [rdr_pkg::Q_W-1:0] q_out
);
	import rdr_pkg::*;

	localparam int NST = (Q_W + DIV_STEPS - 1) / DIV_STEPS;

	tag_t           tag_s [0:NST];
	logic [33:0]    rem_s [0:NST];
	logic [32:0]    den_s [0:NST];
	logic [Q_W-1:0] quo_s [0:NST];

	assign tag_s[0] = tag_in;
	assign rem_s[0] = {2'b00, num_in};
	assign den_s[0] = den_in;
	assign quo_s[0] = '0;

	// restoring division, DIV_STEPS quotient bits per stage; first bit is q >= 2^30
	for (genvar s = 0; s < NST; s++) begin : g_st
		logic [33:0]    r;
		logic [Q_W-1:0] q;

		always_comb begin
			r = rem_s[s];
			q = quo_s[s];
			for (int i = 0; i < DIV_STEPS; i++) begin
				if (s * DIV_STEPS + i < Q_W) begin
					if (s * DIV_STEPS + i != 0) begin
						r = r << 1;
					end
					if (r >= {1'b0, den_s[s]}) begin
						r = r - {1'b0, den_s[s]};
						q = {q[Q_W-2:0], 1'b1};
					end else begin
						q = {q[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[s+1] <= '0;
			end else if (en) begin
				tag_s[s+1] <= tag_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1] <= r;
				den_s[s+1] <= den_s[s];
				quo_s[s+1] <= q;
			end
		end
	end

	assign tag_out = tag_s[NST];
	assign q_out   = quo_s[NST];

endmodule

@@ src/rdr_log2.sv @@
module rdr_log2 (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  rdr_pkg::tag_t tag_in,
	input  logic [rdr_pkg::Q_W-1:0] q_in,
	output rdr_pkg::tag_t tag_out,
	output logic signed [21:0] l_out
);
	import rdr_pkg::*;

	localparam int NSQ = 16;

	// leading one search
	logic [Q_W-1:0] qc;
	logic [4:0]     msb;

	always_comb begin
		qc  = (q_in == '0) ? Q_W'(1) : q_in;
		msb = '0;
		for (int i = 0; i < Q_W; i++) begin
			if (qc[i]) begin
				msb = 5'(i);
			end
		end
	end

	tag_t           tag_sa;
	logic [Q_W-1:0] q_sa;
	logic [4:0]     m_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_sa <= '0;
		end else if (en) begin
			tag_sa <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_sa <= qc;
			m_sa <= msb;
		end
	end

	// normalize to [1,2) in Q30
	tag_t              tag_s [0:NSQ];
	logic [30:0]       x_s   [0:NSQ];
	logic [15:0]       fr_s  [0:NSQ];
	logic signed [5:0] ip_s  [0:NSQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s[0] <= '0;
		end else if (en) begin
			tag_s[0] <= tag_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= q_sa << (5'd30 - m_sa);
			fr_s[0] <= '0;
			ip_s[0] <= $signed({1'b0, m_sa}) - 6'sd30;
		end
	end

	// one fraction bit per squaring stage
	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] y;
		logic [30:0] xn;
		logic        b;

		always_comb begin
			sq = 62'(x_s[k]) * 62'(x_s[k]);
			y  = sq[61:30];
			b  = y[31];
			xn = b ? y[31:1] : y[30:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]  <= xn;
				fr_s[k+1] <= {fr_s[k][14:0], b};
				ip_s[k+1] <= ip_s[k];
			end
		end
	end

	assign tag_out = tag_s[NSQ];
	assign l_out   = {ip_s[NSQ], fr_s[NSQ]};

endmodule
